>>> sv/bptc_pkg.sv
package bptc_pkg;

    // field and register widths
    localparam int RAW_W     = 24;
    localparam int CAL_W     = 16;
    localparam int OUT_W     = 32;
    localparam int CFG_IDX_W = 3;

    // scale factors of the compensation formulas, as shift counts
    localparam int C1_SHIFT   = 15;
    localparam int C2_SHIFT   = 16;
    localparam int C5_SHIFT   = 8;
    localparam int TEMP_SHIFT = 23;
    localparam int OFF_SHIFT  = 7;
    localparam int SENS_SHIFT = 8;
    localparam int T2_SHIFT   = 31;
    localparam int P_SHIFT_HI = 21;
    localparam int P_SHIFT_LO = 15;

    // temperature thresholds in hundredths of a degree
    localparam int TEMP_BASE      = 2000;
    localparam int TEMP_VERY_COLD = -1500;

    // internal widths, sized to the value ranges of the integer formulas
    localparam int DT_W      = RAW_W + 1;
    localparam int COEF_W    = CAL_W + 1;
    localparam int DT_PROD_W = DT_W + COEF_W;
    localparam int DT_SQ_W   = 2 * DT_W;
    localparam int TEMP_W    = 21;
    localparam int T2_W      = 18;
    localparam int OFF_W     = 36;
    localparam int SENS_W    = 36;
    localparam int A_W       = TEMP_W + 1;
    localparam int A_SQ_W    = 2 * A_W;
    localparam int SQ_W      = 35;
    localparam int CORR_W    = 39;
    localparam int OFFC_W    = 41;
    localparam int SENSC_W   = 41;
    localparam int SPLIT_W   = 21;
    localparam int PP_LO_W   = RAW_W + SPLIT_W;
    localparam int PP_HI_W   = RAW_W + 1 + SENSC_W - SPLIT_W;
    localparam int PROD_W    = PP_HI_W + SPLIT_W;
    localparam int DIFF_W    = 46;

    // calibration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PRESSURE_SENSITIVITY   = 3'd0,
        REG_PRESSURE_OFFSET        = 3'd1,
        REG_SENSITIVITY_TEMP_COEFF = 3'd2,
        REG_OFFSET_TEMP_COEFF      = 3'd3,
        REG_REFERENCE_TEMPERATURE  = 3'd4,
        REG_TEMPERATURE_COEFF      = 3'd5
    } cal_idx_t;

    typedef struct packed {
        logic [RAW_W-1:0] raw_pressure;
        logic [RAW_W-1:0] raw_temperature;
    } in_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] temperature;
        logic signed [OUT_W-1:0] pressure;
    } out_t;

    typedef struct packed {
        logic [CAL_W-1:0] pressure_sensitivity;
        logic [CAL_W-1:0] pressure_offset;
        logic [CAL_W-1:0] sensitivity_temp_coeff;
        logic [CAL_W-1:0] offset_temp_coeff;
        logic [CAL_W-1:0] reference_temperature;
        logic [CAL_W-1:0] temperature_coeff;
    } cal_t;

    // corrected terms handed from the temperature section to the pressure section
    typedef struct packed {
        logic signed [TEMP_W-1:0]  temp;
        logic signed [OFFC_W-1:0]  off;
        logic signed [SENSC_W-1:0] sens;
        logic [RAW_W-1:0]          raw_pressure;
    } front_t;

endpackage

>>> sv/bptc_cfg.sv
module bptc_cfg
    import bptc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CAL_W-1:0]     cfg_data,
    output cal_t                 cal
);

    cal_t cal_reg;
    cal_t cal_next;

    assign cfg_ready = 1'b1;
    assign cal       = cal_reg;

    // register write decode, unknown indexes are dropped
    always_comb begin
        cal_next = cal_reg;
        if (cfg_valid) begin
            case (cal_idx_t'(cfg_index))
                REG_PRESSURE_SENSITIVITY:   cal_next.pressure_sensitivity   = cfg_data;
                REG_PRESSURE_OFFSET:        cal_next.pressure_offset        = cfg_data;
                REG_SENSITIVITY_TEMP_COEFF: cal_next.sensitivity_temp_coeff = cfg_data;
                REG_OFFSET_TEMP_COEFF:      cal_next.offset_temp_coeff      = cfg_data;
                REG_REFERENCE_TEMPERATURE:  cal_next.reference_temperature  = cfg_data;
                REG_TEMPERATURE_COEFF:      cal_next.temperature_coeff      = cfg_data;
                default:                    cal_next = cal_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_reg <= '0;
        end else begin
            cal_reg <= cal_next;
        end
    end

endmodule

>>> sv/bptc_front.sv
module bptc_front
    import bptc_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  cal_t   cal,
    input  logic   in_valid,
    output logic   in_ready,
    input  in_t    in_data,
    output logic   out_valid,
    input  logic   out_ready,
    output front_t out_data
);

    localparam int STAGES = 6;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES-1:0] load;
    logic [STAGES-1:0] en;

    logic [RAW_W-1:0] raw_p_reg [STAGES];

    // stage 0: temperature difference
    logic signed [DT_W-1:0] dt_next, dt_reg;
    // stage 1: products with dT
    logic signed [DT_PROD_W-1:0] m6_next, m6_reg;
    logic signed [DT_PROD_W-1:0] m4_next, m4_reg;
    logic signed [DT_PROD_W-1:0] m3_next, m3_reg;
    logic signed [DT_SQ_W-1:0]   mdd_next, mdd_reg;
    // stage 2: first-order terms
    logic signed [DT_PROD_W-1:0] m6_sh, m4_sh, m3_sh;
    logic signed [TEMP_W-1:0]    temp_next, temp2_reg;
    logic signed [OFF_W-1:0]     off_next, off2s_reg;
    logic signed [SENS_W-1:0]    sens_next, sens2s_reg;
    logic [T2_W-1:0]             t2_next, t2_reg;
    logic [OFF_W-1:0]            off_base;
    logic [SENS_W-1:0]           sens_base;
    // stage 3: squares for the cold correction
    logic signed [A_W-1:0]    a_val, b_val;
    logic signed [A_SQ_W-1:0] a_sq, b_sq;
    logic [SQ_W-1:0]          sq_next, sq_reg;
    logic [SQ_W-1:0]          sqb_next, sqb_reg;
    logic                     cold_next, cold_reg;
    logic                     vcold_next, vcold_reg;
    logic signed [TEMP_W-1:0] temp3_reg;
    logic [T2_W-1:0]          t2_3_reg;
    logic signed [OFF_W-1:0]  off3_reg;
    logic signed [SENS_W-1:0] sens3_reg;
    // stage 4: correction terms and corrected temperature
    logic [CORR_W-1:0]        sq_x, sqb_x, five_sq, seven_sqb, eleven_sqb;
    logic [CORR_W-1:0]        off2_next, off2_reg;
    logic [CORR_W-1:0]        sens2_next, sens2_reg;
    logic signed [TEMP_W-1:0] t2_eff;
    logic signed [TEMP_W-1:0] tempc_next, temp4_reg;
    logic signed [OFF_W-1:0]  off4_reg;
    logic signed [SENS_W-1:0] sens4_reg;
    // stage 5: corrected offset and sensitivity
    logic signed [OFFC_W-1:0]  offc_next, offc_reg;
    logic signed [SENSC_W-1:0] sensc_next, sensc_reg;
    logic signed [TEMP_W-1:0]  temp5_reg;

    // stage flow control: a stage loads when empty or when its content moves on
    always_comb begin
        load[STAGES-1] = !valid_reg[STAGES-1] || out_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            load[k] = !valid_reg[k] || load[k+1];
        end
        valid_next[0] = in_valid;
        for (int k = 1; k < STAGES; k++) begin
            valid_next[k] = valid_reg[k-1];
        end
        en = load & valid_next;
    end

    assign in_ready  = load[0];
    assign out_valid = valid_reg[STAGES-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int k = 0; k < STAGES; k++) begin
                if (load[k]) begin
                    valid_reg[k] <= valid_next[k];
                end
            end
        end
    end

    // raw pressure rides along
    always_ff @(posedge aclk) begin
        if (en[0]) begin
            raw_p_reg[0] <= in_data.raw_pressure;
        end
        for (int k = 1; k < STAGES; k++) begin
            if (en[k]) begin
                raw_p_reg[k] <= raw_p_reg[k-1];
            end
        end
    end

    // stage 0: dT = D2 - C5 * 2^8
    assign dt_next = $signed({1'b0, in_data.raw_temperature})
                   - $signed({1'b0, cal.reference_temperature, {C5_SHIFT{1'b0}}});

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            dt_reg <= dt_next;
        end
    end

    // stage 1: dT times the coefficients and dT squared
    assign m6_next  = dt_reg * $signed({1'b0, cal.temperature_coeff});
    assign m4_next  = dt_reg * $signed({1'b0, cal.offset_temp_coeff});
    assign m3_next  = dt_reg * $signed({1'b0, cal.sensitivity_temp_coeff});
    assign mdd_next = dt_reg * dt_reg;

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            m6_reg  <= m6_next;
            m4_reg  <= m4_next;
            m3_reg  <= m3_next;
            mdd_reg <= mdd_next;
        end
    end

    // stage 2: TEMP, OFF, SENS and T2
    assign m6_sh     = m6_reg >>> TEMP_SHIFT;
    assign m4_sh     = m4_reg >>> OFF_SHIFT;
    assign m3_sh     = m3_reg >>> SENS_SHIFT;
    assign off_base  = {{(OFF_W - CAL_W - C2_SHIFT){1'b0}}, cal.pressure_offset,
                        {C2_SHIFT{1'b0}}};
    assign sens_base = {{(SENS_W - CAL_W - C1_SHIFT){1'b0}}, cal.pressure_sensitivity,
                        {C1_SHIFT{1'b0}}};
    assign temp_next = $signed(m6_sh[TEMP_W-1:0]) + TEMP_W'(TEMP_BASE);
    assign off_next  = $signed(off_base) + $signed(m4_sh[OFF_W-1:0]);
    assign sens_next = $signed(sens_base) + $signed(m3_sh[SENS_W-1:0]);
    assign t2_next   = mdd_reg[T2_SHIFT +: T2_W];

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            temp2_reg  <= temp_next;
            off2s_reg  <= off_next;
            sens2s_reg <= sens_next;
            t2_reg     <= t2_next;
        end
    end

    // stage 3: (TEMP - 2000)^2, (TEMP + 1500)^2 and the cold flags
    assign a_val      = $signed({temp2_reg[TEMP_W-1], temp2_reg}) - A_W'(TEMP_BASE);
    assign b_val      = $signed({temp2_reg[TEMP_W-1], temp2_reg}) - A_W'(TEMP_VERY_COLD);
    assign a_sq       = a_val * a_val;
    assign b_sq       = b_val * b_val;
    assign sq_next    = a_sq[SQ_W-1:0];
    assign sqb_next   = b_sq[SQ_W-1:0];
    assign cold_next  = temp2_reg < TEMP_W'(TEMP_BASE);
    assign vcold_next = temp2_reg < TEMP_W'(TEMP_VERY_COLD);

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            sq_reg    <= sq_next;
            sqb_reg   <= sqb_next;
            cold_reg  <= cold_next;
            vcold_reg <= vcold_next;
            temp3_reg <= temp2_reg;
            t2_3_reg  <= t2_reg;
            off3_reg  <= off2s_reg;
            sens3_reg <= sens2s_reg;
        end
    end

    // stage 4: OFF2, SENS2 and TEMP - T2
    assign sq_x       = CORR_W'(sq_reg);
    assign sqb_x      = CORR_W'(sqb_reg);
    assign five_sq    = (sq_x << 2) + sq_x;
    assign seven_sqb  = (sqb_x << 3) - sqb_x;
    assign eleven_sqb = (sqb_x << 3) + (sqb_x << 1) + sqb_x;

    always_comb begin
        off2_next  = '0;
        sens2_next = '0;
        if (cold_reg) begin
            off2_next  = five_sq >> 1;
            sens2_next = five_sq >> 2;
            if (vcold_reg) begin
                off2_next  = (five_sq >> 1) + seven_sqb;
                sens2_next = (five_sq >> 2) + (eleven_sqb >> 1);
            end
        end
    end

    assign t2_eff     = cold_reg ? $signed({{(TEMP_W - T2_W){1'b0}}, t2_3_reg})
                                 : $signed({TEMP_W{1'b0}});
    assign tempc_next = temp3_reg - t2_eff;

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            off2_reg  <= off2_next;
            sens2_reg <= sens2_next;
            temp4_reg <= tempc_next;
            off4_reg  <= off3_reg;
            sens4_reg <= sens3_reg;
        end
    end

    // stage 5: OFF - OFF2 and SENS - SENS2
    assign offc_next  = $signed({{(OFFC_W - OFF_W){off4_reg[OFF_W-1]}}, off4_reg})
                      - $signed({{(OFFC_W - CORR_W){1'b0}}, off2_reg});
    assign sensc_next = $signed({{(SENSC_W - SENS_W){sens4_reg[SENS_W-1]}}, sens4_reg})
                      - $signed({{(SENSC_W - CORR_W){1'b0}}, sens2_reg});

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            offc_reg  <= offc_next;
            sensc_reg <= sensc_next;
            temp5_reg <= temp4_reg;
        end
    end

    assign out_data.temp         = temp5_reg;
    assign out_data.off          = offc_reg;
    assign out_data.sens         = sensc_reg;
    assign out_data.raw_pressure = raw_p_reg[STAGES-1];

endmodule

>>> sv/bptc_back.sv
module bptc_back
    import bptc_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   in_valid,
    output logic   in_ready,
    input  front_t in_data,
    output logic   out_valid,
    input  logic   out_ready,
    output out_t   out_data
);

    localparam int STAGES = 4;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES-1:0] load;
    logic [STAGES-1:0] en;

    logic signed [TEMP_W-1:0] temp_reg [STAGES-1];
    logic signed [OFFC_W-1:0] off_reg  [2];

    // stage 0: partial products of D1 * SENS
    logic [SENSC_W-SPLIT_W-1:0] sens_hi;
    logic [PP_LO_W-1:0]         pp_lo_next, pp_lo_reg;
    logic signed [PP_HI_W-1:0]  pp_hi_next, pp_hi_reg;
    // stage 1: full product
    logic signed [PROD_W-1:0]   prod_next, prod_reg;
    // stage 2: D1 * SENS / 2^21 - OFF
    logic signed [PROD_W-1:0]   prod_sh;
    logic signed [DIFF_W-1:0]   diff_next, diff_reg;
    // stage 3: final shift, saturation and output register
    logic signed [DIFF_W-1:0]   p_sh;
    logic [DIFF_W-OUT_W:0]      p_upper;
    logic signed [OUT_W-1:0]    p_next;
    logic signed [OUT_W-1:0]    t_next;
    out_t                       out_reg;

    // stage flow control, the last stage is the output register
    always_comb begin
        load[STAGES-1] = !valid_reg[STAGES-1] || out_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            load[k] = !valid_reg[k] || load[k+1];
        end
        valid_next[0] = in_valid;
        for (int k = 1; k < STAGES; k++) begin
            valid_next[k] = valid_reg[k-1];
        end
        en = load & valid_next;
    end

    assign in_ready  = load[0];
    assign out_valid = valid_reg[STAGES-1];
    assign out_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int k = 0; k < STAGES; k++) begin
                if (load[k]) begin
                    valid_reg[k] <= valid_next[k];
                end
            end
        end
    end

    // temperature and offset ride along
    always_ff @(posedge aclk) begin
        if (en[0]) begin
            temp_reg[0] <= in_data.temp;
            off_reg[0]  <= in_data.off;
        end
        if (en[1]) begin
            temp_reg[1] <= temp_reg[0];
            off_reg[1]  <= off_reg[0];
        end
        if (en[2]) begin
            temp_reg[2] <= temp_reg[1];
        end
    end

    // stage 0: split SENS into a signed high and an unsigned low part
    assign sens_hi    = in_data.sens[SENSC_W-1:SPLIT_W];
    assign pp_lo_next = in_data.raw_pressure * in_data.sens[SPLIT_W-1:0];
    assign pp_hi_next = $signed({1'b0, in_data.raw_pressure}) * $signed(sens_hi);

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            pp_lo_reg <= pp_lo_next;
            pp_hi_reg <= pp_hi_next;
        end
    end

    // stage 1: recombine the partial products
    assign prod_next = $signed({pp_hi_reg, {SPLIT_W{1'b0}}})
                     + $signed({{(PROD_W - PP_LO_W){1'b0}}, pp_lo_reg});

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            prod_reg <= prod_next;
        end
    end

    // stage 2: subtract the offset
    assign prod_sh   = prod_reg >>> P_SHIFT_HI;
    assign diff_next = $signed(prod_sh[DIFF_W-1:0])
                     - $signed({{(DIFF_W - OFFC_W){off_reg[1][OFFC_W-1]}}, off_reg[1]});

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            diff_reg <= diff_next;
        end
    end

    // stage 3: scale down and clamp to the 32-bit range
    assign p_sh    = diff_reg >>> P_SHIFT_LO;
    assign p_upper = p_sh[DIFF_W-1:OUT_W-1];

    always_comb begin
        if (&p_upper || ~|p_upper) begin
            p_next = p_sh[OUT_W-1:0];
        end else if (p_sh[DIFF_W-1]) begin
            p_next = $signed({1'b1, {(OUT_W - 1){1'b0}}});
        end else begin
            p_next = $signed({1'b0, {(OUT_W - 1){1'b1}}});
        end
    end

    assign t_next = $signed({{(OUT_W - TEMP_W){temp_reg[2][TEMP_W-1]}}, temp_reg[2]});

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            out_reg.temperature <= t_next;
            out_reg.pressure    <= p_next;
        end
    end

endmodule

>>> sv/baro_pressure_temp_compensation.sv
// Second-order compensation of a barometric sensor: each transfer on the s_ side carries
// one raw 24-bit pressure conversion and one raw 24-bit temperature conversion, and the
// matching transfer on the m_ side gives the temperature in 0.01 degC and the pressure in
// 0.01 mbar, saturated to 32 bits. The six 16-bit calibration words are written through
// the cfg port (index 0 to 5 in PROM order, other indexes ignored); the user must write
// them only while no sample is in flight; the block does not enforce it. A ten-stage
// pipeline (six stages for temperature, offset, sensitivity and the cold correction,
// four for the split 24x41-bit pressure product, offset subtraction and clamp) takes
// one sample pair per cycle unless stalled; m_ready stalls only the full stages.
module baro_pressure_temp_compensation
    import bptc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_t                  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_t                 m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CAL_W-1:0]     cfg_data
);

    cal_t   cal;
    front_t front_data;
    logic   front_valid;
    logic   front_ready;

    // calibration registers
    bptc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cal       (cal)
    );

    // temperature, offset and sensitivity with cold correction
    bptc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cal       (cal),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_data  (front_data)
    );

    // pressure product, offset subtraction and clamp
    bptc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

endmodule
